### rtl/tbo_pkg.sv
// Shared constants and types for the triangle/box overlap test unit.
`default_nettype none

package tbo_pkg;

    // Default coordinate format: signed Q12.12
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 12;

    // Partial-product chunk width of the pipelined multipliers
    localparam int MUL_CHUNK = 32;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5,
        CFG_BOX_TOL   = 3'd6,
        CFG_PROJ_TOL  = 3'd7
    } t_cfg_idx;

    // Early-test outcome carried down the pipeline with each triangle
    typedef struct packed {
        logic miss;
        logic all_in;
        logic degen;
        logic last;
    } t_tri_flags;

endpackage : tbo_pkg

`default_nettype wire

### rtl/tbo_if.sv
// Channel interfaces: triangle input, result output and configuration writes.
`default_nettype none

interface tbo_tri_if import tbo_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex0_x;
    logic signed [COORD_BITS-1:0] vertex0_y;
    logic signed [COORD_BITS-1:0] vertex0_z;
    logic signed [COORD_BITS-1:0] vertex1_x;
    logic signed [COORD_BITS-1:0] vertex1_y;
    logic signed [COORD_BITS-1:0] vertex1_z;
    logic signed [COORD_BITS-1:0] vertex2_x;
    logic signed [COORD_BITS-1:0] vertex2_y;
    logic signed [COORD_BITS-1:0] vertex2_z;
    logic                         last_triangle;

    modport source (
        output valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z, last_triangle,
        input  ready
    );
    modport sink (
        input  valid, vertex0_x, vertex0_y, vertex0_z, vertex1_x, vertex1_y, vertex1_z,
               vertex2_x, vertex2_y, vertex2_z, last_triangle,
        output ready
    );
endinterface : tbo_tri_if

interface tbo_res_if;
    logic valid;
    logic ready;
    logic overlaps;
    logic degenerate;
    logic last_result;

    modport source (output valid, overlaps, degenerate, last_result, input ready);
    modport sink   (input valid, overlaps, degenerate, last_result, output ready);
endinterface : tbo_res_if

interface tbo_cfg_if import tbo_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [COORD_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : tbo_cfg_if

`default_nettype wire

### rtl/triangle_box_overlap_test_unit.sv
// Top level: pipelined triangle versus axis-aligned box separating-axis test.
//
// Usage:
//   i_cfg  - register writes (index, data); always ready. Write only while no
//            triangle is in flight. Registers reset to zero.
//   i_tri  - one triangle per transaction (three vertices, signed fixed point,
//            plus the last_triangle tag).
//   o_res  - one result per triangle, in order: overlaps, degenerate,
//            last_result.
// Throughput is one triangle per cycle while o_res is not stalled; the
// pipeline is 11 register stages long, set by the three chained two-stage
// multiplier groups (plane normal, corner distance, squared distance
// against tolerance).
// When o_res is stalled, the whole pipeline holds under a single enable and
// i_tri.ready drops; stages with bubbles do not advance either.
// Reset (synchronous, active low) clears all stage valid bits and the
// configuration registers.
`default_nettype none

module triangle_box_overlap_test_unit import tbo_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tbo_tri_if.sink   i_tri,
    tbo_res_if.source o_res,
    tbo_cfg_if.sink   i_cfg
);

    localparam int C    = COORD_BITS;
    localparam int NST  = 11;
    localparam int EW   = C + 1;            // edge
    localparam int RW   = C + 1;            // corner relative to vertex 0
    localparam int PPW  = 2 * EW;           // edge product
    localparam int NW   = PPW + 1;          // normal component
    localparam int DPW  = NW + RW;          // normal times offset
    localparam int DW   = DPW + 2;          // corner distance
    localparam int SQW  = 2 * NW;
    localparam int NNW  = SQW + 2;          // squared normal length
    localparam int TW   = C - 1;            // tolerance
    localparam int T2W  = 2 * (TW + 1);
    localparam int RHW  = T2W + NNW;
    localparam int DSQW = 2 * DW;
    localparam int CMPW = ((DSQW > RHW) ? DSQW : RHW) + 1;
    localparam int XPW  = C + EW;           // coordinate times edge
    localparam int XSW  = XPW + 1;          // cross-axis projection
    localparam int SLW  = TW + FRAC_BITS;   // shifted projection slack
    localparam int SW   = ((XSW > SLW + 1) ? XSW : SLW + 1) + 2;

    // ------------------------------------------------------------------
    // Configuration registers
    logic signed [C-1:0] r_lo [3];
    logic signed [C-1:0] r_hi [3];
    logic [TW-1:0]       r_tol;
    logic [TW-1:0]       r_ptol;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= '0;
                r_hi[j] <= '0;
            end
            r_tol  <= '0;
            r_ptol <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_BOX_MIN_X: r_lo[0] <= $signed(i_cfg.data);
                CFG_BOX_MIN_Y: r_lo[1] <= $signed(i_cfg.data);
                CFG_BOX_MIN_Z: r_lo[2] <= $signed(i_cfg.data);
                CFG_BOX_MAX_X: r_hi[0] <= $signed(i_cfg.data);
                CFG_BOX_MAX_Y: r_hi[1] <= $signed(i_cfg.data);
                CFG_BOX_MAX_Z: r_hi[2] <= $signed(i_cfg.data);
                CFG_BOX_TOL:   r_tol   <= i_cfg.data[TW-1:0];
                CFG_PROJ_TOL:  r_ptol  <= i_cfg.data[TW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: one enable for every stage
    logic [NST:1] r_v;
    logic         en;

    assign en          = !r_v[NST] || o_res.ready;
    assign i_tri.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-1:1], i_tri.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register
    logic signed [C-1:0] r_p [3][3];
    logic                r_last1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0][0] <= i_tri.vertex0_x;
            r_p[0][1] <= i_tri.vertex0_y;
            r_p[0][2] <= i_tri.vertex0_z;
            r_p[1][0] <= i_tri.vertex1_x;
            r_p[1][1] <= i_tri.vertex1_y;
            r_p[1][2] <= i_tri.vertex1_z;
            r_p[2][0] <= i_tri.vertex2_x;
            r_p[2][1] <= i_tri.vertex2_y;
            r_p[2][2] <= i_tri.vertex2_z;
            r_last1   <= i_tri.last_triangle;
        end
    end

    // Edges, bounds tests, degenerate edges, corner offsets
    logic signed [RW-1:0] tol_s;
    logic signed [RW-1:0] s1_lo_w [3];
    logic signed [RW-1:0] s1_hi_w [3];
    logic signed [EW-1:0] s1_e [3][3];
    logic signed [RW-1:0] s1_rlo [3];
    logic signed [RW-1:0] s1_rhi [3];
    logic [2:0]           s1_above;
    logic [2:0]           s1_below;
    t_tri_flags           s1_f;

    assign tol_s = $signed({2'b00, r_tol});

    always_comb begin
        s1_f.all_in = 1'b1;
        s1_f.degen  = 1'b0;
        s1_f.last   = r_last1;
        for (int j = 0; j < 3; j++) begin
            s1_lo_w[j]  = RW'(r_lo[j]) - tol_s;
            s1_hi_w[j]  = RW'(r_hi[j]) + tol_s;
            s1_e[0][j]  = EW'(r_p[1][j]) - EW'(r_p[0][j]);
            s1_e[1][j]  = EW'(r_p[2][j]) - EW'(r_p[0][j]);
            s1_e[2][j]  = EW'(r_p[2][j]) - EW'(r_p[1][j]);
            s1_rlo[j]   = RW'(r_lo[j]) - RW'(r_p[0][j]);
            s1_rhi[j]   = RW'(r_hi[j]) - RW'(r_p[0][j]);
            s1_above[j] = 1'b1;
            s1_below[j] = 1'b1;
            for (int v = 0; v < 3; v++) begin
                if (RW'(r_p[v][j]) <= s1_hi_w[j]) s1_above[j] = 1'b0;
                if (RW'(r_p[v][j]) >= s1_lo_w[j]) s1_below[j] = 1'b0;
                if (RW'(r_p[v][j]) < s1_lo_w[j] || RW'(r_p[v][j]) > s1_hi_w[j])
                    s1_f.all_in = 1'b0;
            end
        end
        s1_f.miss = |(s1_above | s1_below);
        for (int i = 0; i < 3; i++) begin
            if (s1_e[i][0] == '0 && s1_e[i][1] == '0 && s1_e[i][2] == '0)
                s1_f.degen = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 registers and flag/offset delay lines
    logic signed [EW-1:0] r_e2 [3][3];
    logic signed [C-1:0]  r_p2 [3][3];
    logic signed [RW-1:0] r_rlo [2:5][3];
    logic signed [RW-1:0] r_rhi [2:5][3];
    t_tri_flags           r_f [2:NST-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e2     <= s1_e;
            r_p2     <= r_p;
            r_rlo[2] <= s1_rlo;
            r_rhi[2] <= s1_rhi;
            r_f[2]   <= s1_f;
            for (int k = 3; k <= 5; k++) begin
                r_rlo[k] <= r_rlo[k-1];
                r_rhi[k] <= r_rhi[k-1];
            end
            for (int k = 3; k <= NST-1; k++) begin
                r_f[k] <= r_f[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-4: normal products and cross-axis projection products
    logic signed [PPW-1:0] s4_na [3];
    logic signed [PPW-1:0] s4_nb [3];
    logic signed [XPW-1:0] s4_lb [3][3];
    logic signed [XPW-1:0] s4_hb [3][3];
    logic signed [XPW-1:0] s4_ld [3][3];
    logic signed [XPW-1:0] s4_hd [3][3];
    logic signed [XPW-1:0] s4_pb [3][3][3];
    logic signed [XPW-1:0] s4_pd [3][3][3];

    for (genvar gj = 0; gj < 3; gj++) begin : g_nrm
        localparam int B = (gj + 1) % 3;
        localparam int D = (gj + 2) % 3;
        tbo_mul #(.AW(EW), .BW(EW)) u_na (
            .i_clk(i_clk), .i_en(en), .i_a(r_e2[0][B]), .i_b(r_e2[2][D]), .o_p(s4_na[gj])
        );
        tbo_mul #(.AW(EW), .BW(EW)) u_nb (
            .i_clk(i_clk), .i_en(en), .i_a(r_e2[0][D]), .i_b(r_e2[2][B]), .o_p(s4_nb[gj])
        );
    end

    // Projection of point c on axis (edge x unit axis a): c_b*e_d - c_d*e_b
    for (genvar gi = 0; gi < 3; gi++) begin : g_edge
        for (genvar ga = 0; ga < 3; ga++) begin : g_axis
            localparam int B = (ga + 1) % 3;
            localparam int D = (ga + 2) % 3;
            tbo_mul #(.AW(C), .BW(EW)) u_lb (
                .i_clk(i_clk), .i_en(en), .i_a(r_lo[B]), .i_b(r_e2[gi][D]),
                .o_p(s4_lb[gi][ga])
            );
            tbo_mul #(.AW(C), .BW(EW)) u_hb (
                .i_clk(i_clk), .i_en(en), .i_a(r_hi[B]), .i_b(r_e2[gi][D]),
                .o_p(s4_hb[gi][ga])
            );
            tbo_mul #(.AW(C), .BW(EW)) u_ld (
                .i_clk(i_clk), .i_en(en), .i_a(r_lo[D]), .i_b(r_e2[gi][B]),
                .o_p(s4_ld[gi][ga])
            );
            tbo_mul #(.AW(C), .BW(EW)) u_hd (
                .i_clk(i_clk), .i_en(en), .i_a(r_hi[D]), .i_b(r_e2[gi][B]),
                .o_p(s4_hd[gi][ga])
            );
            for (genvar gv = 0; gv < 3; gv++) begin : g_vtx
                tbo_mul #(.AW(C), .BW(EW)) u_pb (
                    .i_clk(i_clk), .i_en(en), .i_a(r_p2[gv][B]), .i_b(r_e2[gi][D]),
                    .o_p(s4_pb[gi][ga][gv])
                );
                tbo_mul #(.AW(C), .BW(EW)) u_pd (
                    .i_clk(i_clk), .i_en(en), .i_a(r_p2[gv][D]), .i_b(r_e2[gi][B]),
                    .o_p(s4_pd[gi][ga][gv])
                );
            end
        end
    end

    // Stage 4: normal components, box projection range, vertex projections
    logic signed [XSW-1:0] s4_bmin [3][3];
    logic signed [XSW-1:0] s4_bmax [3][3];
    logic signed [XSW-1:0] s4_t [3][3][3];
    logic signed [NW-1:0]  s4_n [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            s4_n[j] = NW'(s4_na[j]) - NW'(s4_nb[j]);
        end
        for (int i = 0; i < 3; i++) begin
            for (int a = 0; a < 3; a++) begin
                s4_bmin[i][a] = XSW'((s4_lb[i][a] < s4_hb[i][a]) ? s4_lb[i][a] : s4_hb[i][a])
                              - XSW'((s4_ld[i][a] > s4_hd[i][a]) ? s4_ld[i][a] : s4_hd[i][a]);
                s4_bmax[i][a] = XSW'((s4_lb[i][a] > s4_hb[i][a]) ? s4_lb[i][a] : s4_hb[i][a])
                              - XSW'((s4_ld[i][a] < s4_hd[i][a]) ? s4_ld[i][a] : s4_hd[i][a]);
                for (int v = 0; v < 3; v++) begin
                    s4_t[i][a][v] = XSW'(s4_pb[i][a][v]) - XSW'(s4_pd[i][a][v]);
                end
            end
        end
    end

    logic signed [NW-1:0]  r_n5 [3];
    logic signed [XSW-1:0] r_bmin5 [3][3];
    logic signed [XSW-1:0] r_bmax5 [3][3];
    logic signed [XSW-1:0] r_t5 [3][3][3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n5    <= s4_n;
            r_bmin5 <= s4_bmin;
            r_bmax5 <= s4_bmax;
            r_t5    <= s4_t;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: cross-axis interval tests
    logic signed [SW-1:0]  slack;
    logic signed [XSW-1:0] s5_tmin [3][3];
    logic signed [XSW-1:0] s5_tmax [3][3];
    logic                  s5_sep;

    assign slack = $signed(SW'(r_ptol) << FRAC_BITS);

    always_comb begin
        s5_sep = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int a = 0; a < 3; a++) begin
                s5_tmin[i][a] = r_t5[i][a][0];
                s5_tmax[i][a] = r_t5[i][a][0];
                for (int v = 1; v < 3; v++) begin
                    if (r_t5[i][a][v] < s5_tmin[i][a]) s5_tmin[i][a] = r_t5[i][a][v];
                    if (r_t5[i][a][v] > s5_tmax[i][a]) s5_tmax[i][a] = r_t5[i][a][v];
                end
                if ((SW'(r_bmax5[i][a]) + slack < SW'(s5_tmin[i][a])) ||
                    (SW'(r_bmin5[i][a]) > SW'(s5_tmax[i][a]) + slack))
                    s5_sep = 1'b1;
            end
        end
    end

    logic r_ax [6:NST-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax[6] <= s5_sep;
            for (int k = 7; k <= NST-1; k++) begin
                r_ax[k] <= r_ax[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 5-7: corner offset products, squared normal, squared tolerance
    logic signed [DPW-1:0] s7_dlo [3];
    logic signed [DPW-1:0] s7_dhi [3];
    logic signed [SQW-1:0] s7_sq [3];
    logic signed [T2W-1:0] s7_tol2;

    for (genvar gj = 0; gj < 3; gj++) begin : g_pln
        tbo_mul #(.AW(NW), .BW(RW)) u_dlo (
            .i_clk(i_clk), .i_en(en), .i_a(r_n5[gj]), .i_b(r_rlo[5][gj]), .o_p(s7_dlo[gj])
        );
        tbo_mul #(.AW(NW), .BW(RW)) u_dhi (
            .i_clk(i_clk), .i_en(en), .i_a(r_n5[gj]), .i_b(r_rhi[5][gj]), .o_p(s7_dhi[gj])
        );
        tbo_mul #(.AW(NW), .BW(NW)) u_sq (
            .i_clk(i_clk), .i_en(en), .i_a(r_n5[gj]), .i_b(r_n5[gj]), .o_p(s7_sq[gj])
        );
    end

    tbo_mul #(.AW(TW+1), .BW(TW+1)) u_tol2 (
        .i_clk(i_clk), .i_en(en), .i_a($signed({1'b0, r_tol})), .i_b($signed({1'b0, r_tol})),
        .o_p(s7_tol2)
    );

    // Stage 7: nearest and farthest corner distances, squared normal length
    logic signed [DW-1:0]  s7_dmin;
    logic signed [DW-1:0]  s7_dmax;
    logic signed [NNW-1:0] s7_nn;

    always_comb begin
        s7_dmin = '0;
        s7_dmax = '0;
        s7_nn   = '0;
        for (int j = 0; j < 3; j++) begin
            s7_dmin = s7_dmin + DW'((s7_dlo[j] < s7_dhi[j]) ? s7_dlo[j] : s7_dhi[j]);
            s7_dmax = s7_dmax + DW'((s7_dlo[j] > s7_dhi[j]) ? s7_dlo[j] : s7_dhi[j]);
            s7_nn   = s7_nn + NNW'(s7_sq[j]);
        end
    end

    logic signed [DW-1:0]  r_dmin8;
    logic signed [DW-1:0]  r_dmax8;
    logic signed [NNW-1:0] r_nn8;
    logic signed [T2W-1:0] r_tol2_8;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmin8  <= s7_dmin;
            r_dmax8  <= s7_dmax;
            r_nn8    <= s7_nn;
            r_tol2_8 <= s7_tol2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: pick the corner that could be beyond; all corners share a side
    // only if the nearest one (positive side) or farthest one (negative) does
    logic                 s8_cand;
    logic signed [DW-1:0] s8_sel;

    assign s8_cand = (r_dmin8 > $signed(DW'(0))) || (r_dmax8 < $signed(DW'(0)));
    assign s8_sel  = (r_dmin8 > $signed(DW'(0))) ? r_dmin8 : r_dmax8;

    logic signed [DSQW-1:0] s10_dsq;
    logic signed [RHW-1:0]  s10_rhs;

    tbo_mul #(.AW(DW), .BW(DW)) u_dsq (
        .i_clk(i_clk), .i_en(en), .i_a(s8_sel), .i_b(s8_sel), .o_p(s10_dsq)
    );
    tbo_mul #(.AW(T2W), .BW(NNW)) u_rhs (
        .i_clk(i_clk), .i_en(en), .i_a(r_tol2_8), .i_b(r_nn8), .o_p(s10_rhs)
    );

    logic r_cand [9:10];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cand[9]  <= s8_cand;
            r_cand[10] <= r_cand[9];
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: plane test and final decision into the output register
    logic s10_psep;
    logic s10_hit;
    logic s10_dgn;

    assign s10_psep = r_cand[10] && (CMPW'(s10_dsq) > CMPW'(s10_rhs));
    assign s10_hit  = !r_f[10].miss &&
                      (r_f[10].all_in || (!r_f[10].degen && !s10_psep && !r_ax[10]));
    assign s10_dgn  = !r_f[10].miss && !r_f[10].all_in && r_f[10].degen;

    logic r_ovl;
    logic r_dgn;
    logic r_lst;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ovl <= s10_hit;
            r_dgn <= s10_dgn;
            r_lst <= r_f[10].last;
        end
    end

    assign o_res.valid       = r_v[NST];
    assign o_res.overlaps    = r_ovl;
    assign o_res.degenerate  = r_dgn;
    assign o_res.last_result = r_lst;

`ifndef SYNTHESIS
    // A result flagged degenerate never reports a hit
    a_degen_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.degenerate && o_res.overlaps))
        else $error("degenerate result flagged as overlap");

    // A waiting result blocks new triangles
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_tri.ready)
        else $error("input accepted while output stalled");

    // An accepted triangle enters stage 1
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_tri.valid && i_tri.ready) |=> r_v[1])
        else $error("accepted triangle lost at pipeline entry");

    // A bounds miss always ends as no hit
    a_miss_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v[10] && r_f[10].miss) |=> (o_res.valid && !o_res.overlaps))
        else $error("bounds miss reported as overlap");
`endif

endmodule : triangle_box_overlap_test_unit

`default_nettype wire

### rtl/tbo_mul.sv
// Two-stage signed multiplier built from registered chunk partial products.
`default_nettype none

module tbo_mul import tbo_pkg::*; #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [AW-1:0]  i_a,
    input  wire logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0]    o_p
);

    localparam int PW  = MUL_CHUNK;
    localparam int NA  = (AW + PW - 1) / PW;
    localparam int NB  = (BW + PW - 1) / PW;
    localparam int PPW = 2 * PW + 2;
    localparam int FW  = (NA + NB) * PW + 2;

    logic signed [NA*PW-1:0] a_ext;
    logic signed [NB*PW-1:0] b_ext;
    logic signed [PPW-1:0]   r_pp [NA][NB];
    logic signed [FW-1:0]    n_acc;
    logic signed [AW+BW-1:0] r_p;

    assign a_ext = (NA*PW)'(i_a);
    assign b_ext = (NB*PW)'(i_b);

    // Stage 1: chunk products; only the top chunk of each operand is signed
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= $signed({(i == NA-1) ? a_ext[NA*PW-1] : 1'b0,
                                           a_ext[i*PW +: PW]})
                                * $signed({(j == NB-1) ? b_ext[NB*PW-1] : 1'b0,
                                           b_ext[j*PW +: PW]});
                end
            end
        end
    end

    // Stage 2: weighted sum of the partial products
    always_comb begin
        n_acc = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_acc = n_acc + (FW'(r_pp[i][j]) <<< ((i + j) * PW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_acc[AW+BW-1:0];
        end
    end

    assign o_p = r_p;

endmodule : tbo_mul

`default_nettype wire

### tb/triangle_box_overlap_test_unit_tb.sv
// Self-checking testbench for the triangle/box overlap test unit.
`timescale 1ns / 1ps

module triangle_box_overlap_test_unit_tb;
    import tbo_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;
    localparam longint CMIN = -(64'sd1 <<< (CB - 1));
    localparam longint TMASK = (64'sd1 <<< (CB - 1)) - 1;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [CB-1:0] v[9];
        logic                 last;
    } face_t;

    typedef struct {
        logic overlaps;
        logic degenerate;
        logic last_result;
    } verdict_t;

    // Queue of predicted verdicts, checked in order against the result channel
    class overlap_scoreboard;
        verdict_t expected_results[$];
        int       mismatches;

        function void note(verdict_t v);
            expected_results.push_back(v);
        endfunction

        function void check(verdict_t got);
            verdict_t want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d%0d%0d", got.overlaps, got.degenerate,
                             got.last_result);
                return;
            end
            want = expected_results.pop_front();
            if (want.overlaps !== got.overlaps || want.degenerate !== got.degenerate ||
                want.last_result !== got.last_result) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected ovl=%0d deg=%0d last=%0d, got %0d %0d %0d",
                             want.overlaps, want.degenerate, want.last_result,
                             got.overlaps, got.degenerate, got.last_result);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    tbo_tri_if face_if ();
    tbo_res_if res_if ();
    tbo_cfg_if cfg_if ();

    triangle_box_overlap_test_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (face_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    overlap_scoreboard sb = new();

    // Shadow copy of the box registers
    longint box_lo[3], box_hi[3], box_tol, proj_tol;
    bit     no_idle;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Interval test along one cross axis
    function automatic bit axis_separates(longint ax[3], longint p[3][3], wide_t slack);
        wide_t s, bmin, bmax, tmin, tmax;
        longint c[3];
        for (int k = 0; k < 8; k++) begin
            c[0] = k[2] ? box_hi[0] : box_lo[0];
            c[1] = k[1] ? box_hi[1] : box_lo[1];
            c[2] = k[0] ? box_hi[2] : box_lo[2];
            s = '0;
            for (int j = 0; j < 3; j++) s += wide_t'(ax[j] * c[j]);
            if (k == 0 || s < bmin) bmin = s;
            if (k == 0 || s > bmax) bmax = s;
        end
        for (int k = 0; k < 3; k++) begin
            s = '0;
            for (int j = 0; j < 3; j++) s += wide_t'(ax[j] * p[k][j]);
            if (k == 0 || s < tmin) tmin = s;
            if (k == 0 || s > tmax) tmax = s;
        end
        return (bmax + slack < tmin) || (bmin > tmax + slack);
    endfunction

    // Overlap verdict for one triangle against the shadow box
    function automatic verdict_t overlap_predict(face_t f);
        verdict_t r;
        longint p[3][3], e[3][3], ax[3], c[3], tmn, tmx;
        wide_t n[3], nn, rhs, d, slack;
        bit all_in, pos, neg, far;
        r.overlaps = 1'b0;
        r.degenerate = 1'b0;
        r.last_result = f.last;
        all_in = 1'b1;
        pos = 1'b1;
        neg = 1'b1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) p[i][j] = longint'(f.v[i*3+j]);
        // bounds and all-inside tests
        for (int j = 0; j < 3; j++) begin
            tmn = p[0][j];
            tmx = p[0][j];
            for (int i = 1; i < 3; i++) begin
                if (p[i][j] < tmn) tmn = p[i][j];
                if (p[i][j] > tmx) tmx = p[i][j];
            end
            if (tmn > box_hi[j] + box_tol || tmx < box_lo[j] - box_tol) return r;
            for (int i = 0; i < 3; i++)
                if (p[i][j] < box_lo[j] - box_tol || p[i][j] > box_hi[j] + box_tol)
                    all_in = 1'b0;
        end
        if (all_in) begin
            r.overlaps = 1'b1;
            return r;
        end
        // zero-length edges
        for (int j = 0; j < 3; j++) begin
            e[0][j] = p[1][j] - p[0][j];
            e[1][j] = p[2][j] - p[0][j];
            e[2][j] = p[2][j] - p[1][j];
        end
        for (int i = 0; i < 3; i++)
            if (e[i][0] == 0 && e[i][1] == 0 && e[i][2] == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
        // plane test, squared distances against squared tolerance
        n[0] = wide_t'(e[0][1] * e[2][2]) - wide_t'(e[0][2] * e[2][1]);
        n[1] = wide_t'(e[0][2] * e[2][0]) - wide_t'(e[0][0] * e[2][2]);
        n[2] = wide_t'(e[0][0] * e[2][1]) - wide_t'(e[0][1] * e[2][0]);
        nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        rhs = wide_t'(box_tol * box_tol) * nn;
        for (int k = 0; k < 8; k++) begin
            c[0] = k[2] ? box_hi[0] : box_lo[0];
            c[1] = k[1] ? box_hi[1] : box_lo[1];
            c[2] = k[0] ? box_hi[2] : box_lo[2];
            d = '0;
            for (int j = 0; j < 3; j++) d += n[j] * wide_t'(c[j] - p[0][j]);
            far = (d * d) > rhs;
            if (!(far && d > 0)) pos = 1'b0;
            if (!(far && d < 0)) neg = 1'b0;
        end
        if (pos || neg) return r;
        // edge-by-axis projections, every edge against every axis
        slack = wide_t'(proj_tol <<< FB);
        for (int i = 0; i < 3; i++) begin
            for (int a = 0; a < 3; a++) begin
                case (a)
                    0: begin ax[0] = 0;        ax[1] = e[i][2];  ax[2] = -e[i][1]; end
                    1: begin ax[0] = -e[i][2]; ax[1] = 0;        ax[2] = e[i][0];  end
                    default: begin ax[0] = e[i][1]; ax[1] = -e[i][0]; ax[2] = 0; end
                endcase
                if (axis_separates(ax, p, slack)) return r;
            end
        end
        r.overlaps = 1'b1;
        return r;
    endfunction

    // Result side: random stall per transaction, checked at acceptance
    int res_wait;
    always @(posedge i_clk) begin
        verdict_t got;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_wait <= 0;
        end else if (res_if.valid && res_if.ready) begin
            got.overlaps = res_if.overlaps;
            got.degenerate = res_if.degenerate;
            got.last_result = res_if.last_result;
            sb.check(got);
            res_wait <= no_idle ? 0 : $urandom_range(0, 6);
            if (!no_idle && $urandom_range(0, 1)) res_if.ready <= 1'b0;
        end else if (!res_if.ready) begin
            if (res_wait <= 1) res_if.ready <= 1'b1;
            res_wait <= res_wait - 1;
        end
    end

    // One register write; valid stays high across consecutive writes
    task automatic cfg_write(t_cfg_idx idx, longint value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value[CB-1:0];
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_BOX_MIN_X: box_lo[0] = longint'(signed'(value[CB-1:0]));
            CFG_BOX_MIN_Y: box_lo[1] = longint'(signed'(value[CB-1:0]));
            CFG_BOX_MIN_Z: box_lo[2] = longint'(signed'(value[CB-1:0]));
            CFG_BOX_MAX_X: box_hi[0] = longint'(signed'(value[CB-1:0]));
            CFG_BOX_MAX_Y: box_hi[1] = longint'(signed'(value[CB-1:0]));
            CFG_BOX_MAX_Z: box_hi[2] = longint'(signed'(value[CB-1:0]));
            CFG_BOX_TOL:   box_tol = value & TMASK;
            default:       proj_tol = value & TMASK;
        endcase
    endtask

    task automatic set_box(longint lx, longint ly, longint lz, longint hx, longint hy,
                           longint hz, longint bt, longint pt);
        cfg_write(CFG_BOX_MIN_X, lx);
        cfg_write(CFG_BOX_MIN_Y, ly);
        cfg_write(CFG_BOX_MIN_Z, lz);
        cfg_write(CFG_BOX_MAX_X, hx);
        cfg_write(CFG_BOX_MAX_Y, hy);
        cfg_write(CFG_BOX_MAX_Z, hz);
        cfg_write(CFG_BOX_TOL, bt);
        cfg_write(CFG_PROJ_TOL, pt);
        cfg_if.valid <= 1'b0;
    endtask

    // One triangle transaction; valid stays high across back-to-back items
    task automatic send_face(face_t f);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            face_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        face_if.vertex0_x <= f.v[0];
        face_if.vertex0_y <= f.v[1];
        face_if.vertex0_z <= f.v[2];
        face_if.vertex1_x <= f.v[3];
        face_if.vertex1_y <= f.v[4];
        face_if.vertex1_z <= f.v[5];
        face_if.vertex2_x <= f.v[6];
        face_if.vertex2_y <= f.v[7];
        face_if.vertex2_z <= f.v[8];
        face_if.last_triangle <= f.last;
        face_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!face_if.ready) @(posedge i_clk);
        sb.note(overlap_predict(f));
    endtask

    task automatic send_coords(longint a0, longint a1, longint a2, longint b0, longint b1,
                               longint b2, longint c0, longint c1, longint c2, bit lst);
        face_t f;
        f.v[0] = CB'(a0); f.v[1] = CB'(a1); f.v[2] = CB'(a2);
        f.v[3] = CB'(b0); f.v[4] = CB'(b1); f.v[5] = CB'(b2);
        f.v[6] = CB'(c0); f.v[7] = CB'(c1); f.v[8] = CB'(c2);
        f.last = lst;
        send_face(f);
    endtask

    // Coordinate around the box extent on one axis, clamped to the field range
    function automatic longint near_box(int j);
        longint lo, hi, m, r;
        lo = box_lo[j] < box_hi[j] ? box_lo[j] : box_hi[j];
        hi = box_lo[j] < box_hi[j] ? box_hi[j] : box_lo[j];
        m = (hi - lo) / 2 + box_tol + 64;
        r = lo - m + longint'($urandom_range(0, 32'(hi - lo + 2 * m)));
        if (r > CMAX) r = CMAX;
        if (r < CMIN) r = CMIN;
        return r;
    endfunction

    task automatic send_random_face();
        face_t f;
        int mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++)
            f.v[i] = (mode == 0) ? CB'($urandom) : CB'(near_box(i % 3));
        if (mode == 1) begin
            // repeated vertex
            for (int j = 0; j < 3; j++) f.v[3 + j] = f.v[j];
        end else if (mode == 2) begin
            // collinear vertices
            for (int j = 0; j < 3; j++) f.v[6 + j] = CB'(2 * f.v[3 + j] - f.v[j]);
        end
        f.last = 1'($urandom_range(0, 1));
        send_face(f);
    endtask

    task automatic drain();
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) send_random_face();
        face_if.valid <= 1'b0;
        drain();
    endtask

    function automatic longint rnd_coord();
        return longint'(signed'(CB'($urandom)));
    endfunction

    initial begin
        longint a, b;
        i_rst_n = 1'b0;
        no_idle = 1'b0;
        face_if.valid = 1'b0;
        face_if.vertex0_x = '0; face_if.vertex0_y = '0; face_if.vertex0_z = '0;
        face_if.vertex1_x = '0; face_if.vertex1_y = '0; face_if.vertex1_z = '0;
        face_if.vertex2_x = '0; face_if.vertex2_y = '0; face_if.vertex2_z = '0;
        face_if.last_triangle = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_BOX_MIN_X;
        cfg_if.data = '0;
        for (int j = 0; j < 3; j++) begin
            box_lo[j] = 0;
            box_hi[j] = 0;
        end
        box_tol = 0;
        proj_tol = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset box: a single point at the origin
        send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_coords(-4096, 0, 0, 4096, 0, 0, 0, 4096, 0, 0);
        face_if.valid <= 1'b0;
        drain();

        // directed cases on a unit box
        set_box(-4096, -4096, -4096, 4096, 4096, 4096, 0, 0);
        send_coords(0, 0, 0, 100, 0, 0, 0, 100, 0, 0);            // all inside
        send_coords(9000, 9000, 9000, 9100, 9000, 9000, 9000, 9100, 9000, 1); // bounds miss
        send_coords(5000, 0, 0, 5000, 0, 0, 0, 5000, 0, 0);       // zero-length edge
        send_coords(5000, 0, 0, 0, 5000, 0, 5000, 0, 0, 1);       // degenerate, other edge
        send_coords(-9000, -9000, 0, 9000, -9000, 0, 0, 9000, 0, 0); // crossing slab
        send_coords(-9000, 0, 6000, 9000, 0, 6000, 0, 9000, 6000, 0); // plane beyond
        send_coords(7000, 0, -9000, 0, 7000, -9000, 7000, 7000, 9000, 1); // near corner
        send_coords(-9000, -9000, -9000, 9000, 9000, 9000, 18000, 18000, 18000, 0); // line
        send_coords(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 1);
        send_coords(CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, 0);
        send_coords(CMAX, CMAX, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX, 1);
        face_if.valid <= 1'b0;
        drain();

        // two of the same cases with both tolerances at their maximum
        set_box(-4096, -4096, -4096, 4096, 4096, 4096, TMASK, TMASK);
        send_coords(-9000, 0, 6000, 9000, 0, 6000, 0, 9000, 6000, 0);
        send_coords(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 1);
        face_if.valid <= 1'b0;
        drain();

        // random phases over several box settings
        for (int ph = 0; ph < 9; ph++) begin
            no_idle = (ph % 3 == 1);
            case (ph)
                0: set_box(-4096, -8192, -2048, 4096, 8192, 2048, 16, 16);
                1: set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0);
                2: set_box(4096, 4096, 4096, -4096, -4096, -4096, 200, 300); // inverted
                3: set_box(0, 0, 0, 0, 0, 0, 2000, 0);
                4: set_box(-20000, -20000, -20000, 20000, 20000, 20000, TMASK, 0);
                5: set_box(-20000, -20000, -20000, 20000, 20000, 20000, 0, TMASK);
                default: begin
                    a = rnd_coord() / 2;
                    b = a + $urandom_range(0, 65536);
                    set_box(a, a + $urandom_range(0, 500), a - $urandom_range(0, 500),
                            b, b + $urandom_range(0, 500), b - $urandom_range(0, 500),
                            $urandom_range(0, 3000) | (longint'($urandom_range(0, 1)) << 23),
                            $urandom_range(0, 3000));
                end
            endcase
            random_phase(150);
        end

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("triangle_box_overlap_test_unit_tb OK");
        else
            $display("triangle_box_overlap_test_unit_tb NOT OK");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("triangle_box_overlap_test_unit_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/tbo_pkg.sv
rtl/tbo_if.sv
rtl/tbo_mul.sv
rtl/triangle_box_overlap_test_unit.sv
tb/triangle_box_overlap_test_unit_tb.sv
